[rtl/bfa_pkg.sv]
// Shared types, codes and word helpers for the bitmap frame allocator.
// No dependencies; imported by the core and the checker.
`default_nettype none

package bfa_pkg;

    localparam int WORD_BITS = 32;
    localparam logic [31:0] WORD_FULL = 32'hFFFF_FFFF;

    // request modes, carried on s_tuser
    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_FREE     = 2'd1;
    localparam logic [1:0] MODE_ALLOC_AT = 2'd2;
    localparam logic [1:0] MODE_REGION   = 2'd3;

    // result status, carried on m_tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_USED  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } pe_t;

    // lowest set bit of a word
    function automatic pe_t lowest_set(input logic [31:0] v);
        pe_t r;
        r.found = |v;
        r.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i])
            begin
                r.idx = 5'(i);
            end
        end
        return r;
    endfunction

    // ones from bit lo up to bit hi inclusive
    function automatic logic [31:0] range_mask(input logic [4:0] lo, input logic [4:0] hi);
        return (WORD_FULL << lo) & (WORD_FULL >> (5'd31 - hi));
    endfunction

endpackage

`default_nettype wire

[rtl/bfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the allocator's used-frame bitmap.
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/bitmap_frame_allocator_core.sv]
// Bitmap page-frame allocator: one used bit per frame, kept in a word RAM.
// Depends on bfa_pkg and bfa_ram.
// One request at a time. Free and allocate-at go dispatch, read-modify-write,
// finish. Allocate scans words from 0, writing back only the word with the first
// free frame, up to the last word; a region read-modify-writes each word it spans.
// Both walk one word per cycle. Reversed regions and out-of-range starts go from
// dispatch to finish. A new request is accepted in the cycle the previous result
// goes valid. After reset, with s_tready low, all MAP_WORDS words are cleared.
`default_nettype none

module bitmap_frame_allocator_core #(
    parameter int MAP_WORDS  = 1024,
    parameter int PAGE_BYTES = 4096   // power of two
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // address[31:0], end_address[63:32]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // frame_address[31:0]
    output logic      [1:0]  m_tuser    // status[1:0]
);

    import bfa_pkg::*;

    localparam int WA_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W      = WA_W + 5;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int FRAME_W    = 32 - PAGE_SHIFT;
    localparam int FW         = (FRAME_W > IDX_W) ? FRAME_W : IDX_W;
    localparam int CAP        = MAP_WORDS * WORD_BITS;
    localparam int LAST_OK    = (1 << FRAME_W) - 1;
    localparam int LAST_F     = ((CAP - 1) < LAST_OK) ? (CAP - 1) : LAST_OK;
    localparam int LAST_W     = LAST_F / WORD_BITS;
    localparam int LAST_B     = LAST_F % WORD_BITS;
    localparam logic [32:0] CAP_V = 33'(CAP);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLR    = 7'b0000010,
        S_DISP   = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_RMW    = 7'b0010000,
        S_REGION = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [WA_W-1:0]   w_reg, w_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [1:0]        mode_reg;
    logic [FW-1:0]     start_reg, end_reg;
    logic [IDX_W-1:0]  stop_reg, stop_next;
    logic [31:0]       res_addr_reg, res_addr_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [31:0]       out_addr_reg;
    logic [1:0]        out_status_reg;

    logic              ram_we;
    logic [WA_W-1:0]   ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;

    logic              in_beat, out_load;
    logic [31:0]       avail;
    pe_t               pe;
    logic [4:0]        bit_sel, lo_bit, hi_bit;
    logic              start_oor, end_oor, last_word;
    logic [WA_W-1:0]   w_inc;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WA_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

    assign start_oor = 33'(start_reg) >= CAP_V;
    assign end_oor   = 33'(end_reg) >= CAP_V;
    assign bit_sel   = start_reg[4:0];
    assign w_inc     = WA_W'(w_reg + 1'b1);

    // free bits of the word under scan; frame 0 and unaddressable frames count as used
    always_comb
    begin
        avail = ~ram_rdata;
        if (w_reg == '0)
        begin
            avail[0] = 1'b0;
        end
        if (w_reg == WA_W'(LAST_W))
        begin
            avail = avail & (WORD_FULL >> (5'd31 - 5'(LAST_B)));
        end
        pe = lowest_set(avail);
    end

    assign lo_bit = (w_reg == start_reg[IDX_W-1:5]) ? start_reg[4:0] : 5'd0;
    assign hi_bit = (w_reg == stop_reg[IDX_W-1:5]) ? stop_reg[4:0] : 5'd31;
    assign last_word = (state_reg == S_SCAN) ? (w_reg == WA_W'(LAST_W))
                                             : (w_reg == stop_reg[IDX_W-1:5]);

    always_comb
    begin
        state_next      = state_reg;
        w_next          = w_reg;
        stop_next       = stop_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = w_reg;
        ram_wdata       = '0;
        ram_raddr       = w_reg;
        out_load        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_DISP;
                end
            end
            S_CLR:
            begin
                ram_we = 1'b1;
                w_next = w_inc;
                if (w_reg == WA_W'(MAP_WORDS - 1))
                begin
                    w_next     = '0;
                    state_next = S_IDLE;
                end
            end
            S_DISP:
            begin
                res_addr_next   = '0;
                res_status_next = ST_OK;
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        ram_raddr  = '0;
                        w_next     = '0;
                        state_next = S_SCAN;
                    end
                    MODE_FREE, MODE_ALLOC_AT:
                    begin
                        if (start_oor)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            ram_raddr  = start_reg[IDX_W-1:5];
                            w_next     = start_reg[IDX_W-1:5];
                            state_next = S_RMW;
                        end
                    end
                    default:
                    begin
                        if (start_reg > end_reg)
                        begin
                            state_next = S_FIN;
                        end
                        else if (start_oor)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            if (end_oor)
                            begin
                                res_status_next = ST_RANGE;
                                stop_next       = IDX_W'(CAP - 1);
                            end
                            else
                            begin
                                stop_next = end_reg[IDX_W-1:0];
                            end
                            ram_raddr  = start_reg[IDX_W-1:5];
                            w_next     = start_reg[IDX_W-1:5];
                            state_next = S_REGION;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                ram_raddr = last_word ? w_reg : w_inc;
                if (pe.found)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata | (32'd1 << pe.idx);
                    res_addr_next   = 32'({w_reg, pe.idx}) << PAGE_SHIFT;
                    res_status_next = ST_OK;
                    state_next      = S_FIN;
                end
                else if (last_word)
                begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_FIN;
                end
                else
                begin
                    w_next = w_inc;
                end
            end
            S_RMW:
            begin
                state_next = S_FIN;
                if (mode_reg == MODE_FREE)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~(32'd1 << bit_sel);
                end
                else if (ram_rdata[bit_sel])
                begin
                    res_status_next = ST_USED;
                end
                else
                begin
                    ram_we        = 1'b1;
                    ram_wdata     = ram_rdata | (32'd1 << bit_sel);
                    res_addr_next = 32'(start_reg) << PAGE_SHIFT;
                end
            end
            S_REGION:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | range_mask(lo_bit, hi_bit);
                ram_raddr = last_word ? w_reg : w_inc;
                if (last_word)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    w_next = w_inc;
                end
            end
            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            w_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            w_reg        <= w_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mode_reg  <= s_tuser;
            start_reg <= FW'(s_tdata[31:PAGE_SHIFT]);
            end_reg   <= FW'(s_tdata[63:32] >> PAGE_SHIFT);
        end
        stop_reg       <= stop_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/bfa_checker.sv]
// Port-level checks for the bitmap frame allocator core, plus its bind.
// Depends on bfa_pkg; attaches to bitmap_frame_allocator_core.
`default_nettype none

module bfa_checker #(
    parameter int PAGE_BYTES = 4096
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    import bfa_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one request at a time: input closes right after a beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted beat");

    // a result never appears in the cycle right after a request beat
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early after request");

    // failed requests return a zero address
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> m_tdata == 32'd0)
        else $error("nonzero address on failed request");

    // returned addresses are page aligned
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata & 32'(PAGE_BYTES - 1)) == 32'd0)
        else $error("frame address not page aligned");

endmodule

bind bitmap_frame_allocator_core bfa_checker #(
    .PAGE_BYTES (PAGE_BYTES)
) u_bfa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
